// ===== src/three_level_feedback_scheduler_assert.svh =====
// ============================================================================
// Assertion macros for the three-level feedback scheduler
// Shorthand for clocked concurrent assertions, disabled while in reset.
// ============================================================================
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLFS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tlfs_pkg.sv =====
// ============================================================================
// tlfs_pkg
// Types, sizes, codes and helper functions of the three-level scheduler.
// ============================================================================
package tlfs_pkg;

    localparam int ID_W        = 4;
    localparam int MAX_TASKS   = 1 << ID_W;
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int BURST_WIDTH = 16;
    localparam int NUM_LEVELS  = 3;
    localparam int LVL_W       = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_RAN      = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    localparam logic REG_QUANTUM0 = 1'b0;
    localparam logic REG_QUANTUM1 = 1'b1;

    typedef struct packed {
        logic                   operation;
        logic [ID_W-1:0]        task_id;
        logic [BURST_WIDTH-1:0] burst_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  run_id;
        logic [LVL_W-1:0] run_level;
        logic             finished;
        logic             demoted;
    } t_out_item;

    typedef struct packed {
        logic [BURST_WIDTH-1:0] level0;
        logic [BURST_WIDTH-1:0] level1;
    } t_quanta;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESPOND,
        S_HEAD,
        S_UPDATE
    } t_state;

    function automatic logic [BURST_WIDTH-1:0] eff_quantum(input logic [BURST_WIDTH-1:0] q);
        return (q == '0) ? BURST_WIDTH'(1) : q;
    endfunction

    function automatic logic [QPTR_W-1:0] q_next(input logic [QPTR_W-1:0] ptr);
        return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(ptr + 1'b1);
    endfunction

    function automatic logic [QPTR_W-1:0] q_tail(input logic [QPTR_W-1:0] head,
                                                 input logic [QCNT_W-1:0] count);
        logic [QCNT_W:0] sum;
        sum = (QCNT_W+1)'(head) + (QCNT_W+1)'(count);
        if (sum >= (QCNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (QCNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[QPTR_W-1:0];
    endfunction

endpackage

// ===== src/tlfs_apb_regs.sv =====
// ============================================================================
// tlfs_apb_regs
// Configuration registers holding the level-0 and level-1 time slices.
// ============================================================================
module tlfs_apb_regs
    import tlfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_quanta           o_quanta
);

    logic [BURST_WIDTH-1:0] r_quantum0;
    logic [BURST_WIDTH-1:0] r_quantum1;
    logic                   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum0 <= BURST_WIDTH'(1);
            r_quantum1 <= BURST_WIDTH'(1);
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_QUANTUM0: r_quantum0 <= pwdata[BURST_WIDTH-1:0];
                REG_QUANTUM1: r_quantum1 <= pwdata[BURST_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_QUANTUM0: prdata = APB_DW'(r_quantum0);
            REG_QUANTUM1: prdata = APB_DW'(r_quantum1);
            default: prdata = '0;
        endcase
    end

    assign o_quanta.level0 = r_quantum0;
    assign o_quanta.level1 = r_quantum1;

endmodule

// ===== src/three_level_feedback_scheduler.sv =====
// ============================================================================
// three_level_feedback_scheduler
// Three-level feedback queue scheduler with queue slots and per-task
// counters held in synchronous memories.
// ============================================================================
//  Channel   Signals                              Direction  Content
//  in        i_in_valid, o_in_ready, i_in         input      arrival or tick
//  out       o_out_valid, i_out_ready, o_out      output     one result
//  config    psel, penable, pwrite, paddr, ...    input      quantum registers
//
// An arrival or an idle tick passes through S_RESPOND; a tick that runs a task
// passes through S_HEAD and then S_UPDATE, for the queue memory read followed by the task memory read.
// One item is worked on at a time; the next transfer is taken once the
// result has been placed in the output register.
// A full output register that is not taken holds the engine in its last step.
// Reset empties all levels and clears every active flag.
// ============================================================================
module three_level_feedback_scheduler
    import tlfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_quanta                  quanta;
    t_state                   r_state;
    t_state                   n_state;
    t_in_item                 r_item;
    logic [LVL_W-1:0]         r_lv;
    logic [QPTR_W-1:0]        r_head  [NUM_LEVELS];
    logic [QCNT_W-1:0]        r_count [NUM_LEVELS];
    logic [QPTR_W-1:0]        n_head  [NUM_LEVELS];
    logic [QCNT_W-1:0]        n_count [NUM_LEVELS];
    logic [MAX_TASKS-1:0]     r_active;
    logic [MAX_TASKS-1:0]     n_active;
    logic [ID_W-1:0]          r_qmem  [NUM_LEVELS][QUEUE_DEPTH];
    logic [ID_W-1:0]          r_qrd;
    logic [2*BURST_WIDTH-1:0] r_tmem  [MAX_TASKS];
    logic [2*BURST_WIDTH-1:0] r_trd;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic                     accept;
    logic                     slot_free;
    logic [LVL_W-1:0]         sel_lv;
    logic                     sel_empty;
    logic [LVL_W-1:0]         nxt_lv;
    logic [QPTR_W-1:0]        tail0;
    logic [QPTR_W-1:0]        tail_nxt;
    logic [BURST_WIDTH-1:0]   cur_b;
    logic [BURST_WIDTH-1:0]   cur_q;
    logic [BURST_WIDTH-1:0]   b_dec;
    logic [BURST_WIDTH-1:0]   q_dec;
    logic                     arr_reject;

    logic                     emit;
    t_out_item                out_item;
    logic                     q_we;
    logic [LVL_W-1:0]         q_wlv;
    logic [QPTR_W-1:0]        q_widx;
    logic [ID_W-1:0]          q_wdata;
    logic                     t_we;
    logic [ID_W-1:0]          t_waddr;
    logic [2*BURST_WIDTH-1:0] t_wdata;
    logic                     pop_en;
    logic                     push_en;
    logic [LVL_W-1:0]         push_lv;
    logic                     act_set;
    logic                     act_clr;
    logic [ID_W-1:0]          act_id;

    tlfs_apb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_quanta (quanta)
    );

    assign accept    = i_in_valid & o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        sel_empty = 1'b0;
        if (r_count[0] != '0) begin
            sel_lv = LVL_W'(0);
        end else if (r_count[1] != '0) begin
            sel_lv = LVL_W'(1);
        end else begin
            sel_lv    = LVL_W'(2);
            sel_empty = (r_count[2] == '0);
        end
    end

    assign nxt_lv     = (r_lv == LVL_W'(NUM_LEVELS - 1)) ? r_lv : LVL_W'(r_lv + 1'b1);
    assign tail0      = q_tail(r_head[0], r_count[0]);
    assign tail_nxt   = q_tail(r_head[nxt_lv], r_count[nxt_lv]);
    assign cur_b      = r_trd[2*BURST_WIDTH-1:BURST_WIDTH];
    assign cur_q      = r_trd[BURST_WIDTH-1:0];
    assign b_dec      = (cur_b != '0) ? BURST_WIDTH'(cur_b - 1'b1) : '0;
    assign q_dec      = (cur_q != '0) ? BURST_WIDTH'(cur_q - 1'b1) : '0;
    assign arr_reject = (r_item.burst_length == '0) || r_active[r_item.task_id] ||
                        (r_count[0] >= QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.operation == OP_TICK && !sel_empty) begin
                        n_state = S_HEAD;
                    end else begin
                        n_state = S_RESPOND;
                    end
                end
            end
            S_RESPOND: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_HEAD: n_state = S_UPDATE;
            S_UPDATE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        emit       = 1'b0;
        out_item   = '0;
        q_we       = 1'b0;
        q_wlv      = '0;
        q_widx     = '0;
        q_wdata    = '0;
        t_we       = 1'b0;
        t_waddr    = '0;
        t_wdata    = '0;
        pop_en     = 1'b0;
        push_en    = 1'b0;
        push_lv    = '0;
        act_set    = 1'b0;
        act_clr    = 1'b0;
        act_id     = '0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_RESPOND: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (r_item.operation == OP_TICK) begin
                        out_item.status = ST_IDLE;
                    end else if (arr_reject) begin
                        out_item.status = ST_REJECTED;
                    end else begin
                        out_item.status = ST_ACCEPTED;
                        q_we    = 1'b1;
                        q_wlv   = LVL_W'(0);
                        q_widx  = tail0;
                        q_wdata = r_item.task_id;
                        t_we    = 1'b1;
                        t_waddr = r_item.task_id;
                        t_wdata = {r_item.burst_length, eff_quantum(quanta.level0)};
                        push_en = 1'b1;
                        push_lv = LVL_W'(0);
                        act_set = 1'b1;
                        act_id  = r_item.task_id;
                    end
                end
            end
            S_HEAD: ;
            S_UPDATE: begin
                if (slot_free) begin
                    emit               = 1'b1;
                    out_item.status    = ST_RAN;
                    out_item.run_id    = r_qrd;
                    out_item.run_level = r_lv;
                    t_we               = 1'b1;
                    t_waddr            = r_qrd;
                    t_wdata            = {b_dec, q_dec};
                    if (b_dec == '0) begin
                        out_item.finished = 1'b1;
                        pop_en            = 1'b1;
                        act_clr           = 1'b1;
                        act_id            = r_qrd;
                    end else if (r_lv != LVL_W'(NUM_LEVELS - 1) && q_dec == '0) begin
                        if (r_count[nxt_lv] < QCNT_W'(QUEUE_DEPTH)) begin
                            out_item.demoted = 1'b1;
                            pop_en           = 1'b1;
                            push_en          = 1'b1;
                            push_lv          = nxt_lv;
                            q_we             = 1'b1;
                            q_wlv            = nxt_lv;
                            q_widx           = tail_nxt;
                            q_wdata          = r_qrd;
                            t_wdata = {b_dec, (r_lv == LVL_W'(0)) ?
                                       eff_quantum(quanta.level1) : b_dec};
                        end else begin
                            t_wdata = {b_dec, (r_lv == LVL_W'(0)) ?
                                       eff_quantum(quanta.level0) :
                                       eff_quantum(quanta.level1)};
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            n_head[l]  = r_head[l];
            n_count[l] = r_count[l];
            if (pop_en && r_lv == LVL_W'(l)) begin
                n_head[l]  = q_next(r_head[l]);
                n_count[l] = QCNT_W'(r_count[l] - 1'b1);
            end
            if (push_en && push_lv == LVL_W'(l)) begin
                n_count[l] = QCNT_W'(r_count[l] + 1'b1);
            end
        end
        n_active = r_active;
        if (act_set) begin
            n_active[act_id] = 1'b1;
        end
        if (act_clr) begin
            n_active[act_id] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_head   <= n_head;
            r_count  <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
            r_lv   <= sel_lv;
        end
        if (emit) begin
            r_out <= out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_wlv][q_widx] <= q_wdata;
        end
        if (r_state == S_IDLE) begin
            r_qrd <= r_qmem[sel_lv][r_head[sel_lv]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_waddr] <= t_wdata;
        end
        if (r_state == S_HEAD) begin
            r_trd <= r_tmem[r_qrd];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `include "three_level_feedback_scheduler_assert.svh"

    `TLFS_ASSERT_SAME(a_count_matches_active, 1'b1,
        (int'(r_count[0]) + int'(r_count[1]) + int'(r_count[2])) == $countones(r_active),
        "queued task count differs from active task count")

    `TLFS_ASSERT_SAME(a_count_bounded, 1'b1,
        r_count[0] <= QCNT_W'(QUEUE_DEPTH) && r_count[1] <= QCNT_W'(QUEUE_DEPTH) &&
        r_count[2] <= QCNT_W'(QUEUE_DEPTH),
        "level queue count exceeds its depth")

    `TLFS_ASSERT_NEXT(a_accept_leaves_idle, accept, r_state != S_IDLE,
        "engine stayed idle after an input transfer")

    `TLFS_ASSERT_NEXT(a_finish_clears_active, emit && out_item.finished,
        !r_active[$past(r_qrd)],
        "finished task is still marked active")

endmodule

// ===== verif/tb_three_level_feedback_scheduler.sv =====
// ============================================================================
// Testbench for the three-level feedback scheduler
// Arrivals and ticks are sent over the input channel in random bursts, and
// each result is checked field by field against a scheduler model kept in
// the bench. The quantum registers are changed between phases while the
// block is idle. The phases include zero, minimum and maximum slices, and
// the output side stalls in changing patterns.
// ============================================================================
module tb_three_level_feedback_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import tlfs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 58;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_item          in_item = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_item;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    three_level_feedback_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 i_clk = ~i_clk;

    // Scheduler state mirrored in the bench.
    logic [ID_W-1:0]        level_q [NUM_LEVELS][$];
    logic [BURST_WIDTH-1:0] burst_left [MAX_TASKS];
    logic [BURST_WIDTH-1:0] slice_left [MAX_TASKS];
    bit                     task_on [MAX_TASKS];
    t_quanta                cur_quanta;

    t_in_item  waiting_items[$];
    t_out_item expected_results[$];

    int mismatches = 0;
    int cycle_count = 0;
    int n_accepted = 0, n_rejected = 0, n_ran = 0, n_idle = 0;
    int n_finished = 0, n_demoted = 0;

    function automatic logic [BURST_WIDTH-1:0] level_slice(input int lvl);
        logic [BURST_WIDTH-1:0] q;
        q = (lvl == 0) ? cur_quanta.level0 : cur_quanta.level1;
        return (q == '0) ? BURST_WIDTH'(1) : q;
    endfunction

    function automatic t_out_item schedule_step(input t_in_item it);
        t_out_item       r;
        int              lv;
        logic [ID_W-1:0] t;
        r = '0;
        if (it.operation == OP_ARRIVAL) begin
            if (it.burst_length == '0 || task_on[it.task_id] ||
                level_q[0].size() >= QUEUE_DEPTH) begin
                r.status = ST_REJECTED;
            end else begin
                level_q[0].push_back(it.task_id);
                task_on[it.task_id]    = 1'b1;
                burst_left[it.task_id] = it.burst_length;
                slice_left[it.task_id] = level_slice(0);
                r.status = ST_ACCEPTED;
            end
            return r;
        end
        lv = 0;
        while (lv < NUM_LEVELS && level_q[lv].size() == 0) lv++;
        if (lv == NUM_LEVELS) begin
            r.status = ST_IDLE;
            return r;
        end
        t = level_q[lv][0];
        r.status    = ST_RAN;
        r.run_id    = t;
        r.run_level = LVL_W'(lv);
        if (burst_left[t] != '0) burst_left[t]--;
        if (slice_left[t] != '0) slice_left[t]--;
        if (burst_left[t] == '0) begin
            void'(level_q[lv].pop_front());
            task_on[t] = 1'b0;
            r.finished = 1'b1;
        end else if (lv < 2 && slice_left[t] == '0) begin
            if (level_q[lv+1].size() < QUEUE_DEPTH) begin
                void'(level_q[lv].pop_front());
                level_q[lv+1].push_back(t);
                slice_left[t] = (lv == 0) ? level_slice(1) : burst_left[t];
                r.demoted = 1'b1;
            end else begin
                slice_left[t] = level_slice(lv);
            end
        end
        return r;
    endfunction

    task automatic queue_item(input t_in_item it);
        t_out_item r;
        r = schedule_step(it);
        waiting_items.push_back(it);
        expected_results.push_back(r);
        case (r.status)
            ST_ACCEPTED: n_accepted++;
            ST_REJECTED: n_rejected++;
            ST_RAN:      n_ran++;
            default:     n_idle++;
        endcase
        if (r.finished) n_finished++;
        if (r.demoted)  n_demoted++;
    endtask

    function automatic t_in_item arrival(input int id, input int burst);
        t_in_item it;
        it.operation    = OP_ARRIVAL;
        it.task_id      = ID_W'(id);
        it.burst_length = BURST_WIDTH'(burst);
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       free_ids[$];
        int       busy_ids[$];
        int       roll;
        it.task_id      = ID_W'($urandom_range(0, MAX_TASKS - 1));
        it.burst_length = BURST_WIDTH'($urandom);
        it.operation    = OP_TICK;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (task_on[i]) busy_ids.push_back(i);
            else free_ids.push_back(i);
        end
        roll = $urandom_range(0, 99);
        if (roll < ((free_ids.size() > 8) ? 40 : 15)) begin
            it.operation = OP_ARRIVAL;
            roll = $urandom_range(0, 99);
            if (roll < 88 && free_ids.size() > 0) begin
                it.task_id = ID_W'(free_ids[$urandom_range(0, free_ids.size() - 1)]);
                it.burst_length = ($urandom_range(0, 4) == 0) ?
                                  BURST_WIDTH'($urandom_range(7, 30)) :
                                  BURST_WIDTH'($urandom_range(1, 6));
            end else if (roll < 95 && busy_ids.size() > 0) begin
                it.task_id = ID_W'(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
            end else begin
                it.burst_length = '0;
            end
        end
        return it;
    endfunction

    task automatic apb_write(input int idx, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input int idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(idx * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[BURST_WIDTH-1:0] != want[BURST_WIDTH-1:0]) begin
            mismatches++;
            $display("%0t register %0d read back: expected %0h, actual %0h",
                     $time, idx, want, got);
        end
    endtask

    task automatic set_quanta(input int q0, input int q1);
        apb_write(int'(REG_QUANTUM0), APB_DW'(q0));
        apb_write(int'(REG_QUANTUM1), APB_DW'(q1));
        cur_quanta.level0 = BURST_WIDTH'(q0);
        cur_quanta.level1 = BURST_WIDTH'(q1);
        apb_read_check(int'(REG_QUANTUM0), APB_DW'(q0));
        apb_read_check(int'(REG_QUANTUM1), APB_DW'(q1));
    endtask

    task automatic wait_drained();
        while (waiting_items.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int q0, input int q1);
        set_quanta(q0, q1);
        for (int i = 0; i < PHASE_ITEMS; i++) queue_item(random_item());
        wait_drained();
    endtask

    initial begin
        t_in_item tick;
        for (int i = 0; i < MAX_TASKS; i++) begin
            task_on[i]    = 1'b0;
            burst_left[i] = '0;
            slice_left[i] = '0;
        end
        cur_quanta.level0 = BURST_WIDTH'(1);
        cur_quanta.level1 = BURST_WIDTH'(1);
        tick.operation    = OP_TICK;
        tick.task_id      = '1;
        tick.burst_length = '1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset quanta: idle tick, rejections, and
        // tasks that finish at each of the three levels.
        queue_item(tick);
        queue_item(arrival(0, 0));
        queue_item(arrival(0, 3));
        queue_item(arrival(0, 16'hFFFF));
        queue_item(arrival(15, 1));
        queue_item(arrival(7, 2));
        queue_item(arrival(15, 16'h5555));
        queue_item(arrival(7, 16'hAAAA));
        for (int i = 0; i < 7; i++) queue_item(tick);
        queue_item(arrival(9, 16'h0000));
        queue_item(arrival(9, 4));
        queue_item(arrival(9, 1));
        for (int i = 0; i < 5; i++) queue_item(tick);
        wait_drained();

        run_phase(1, 1);
        run_phase(65535, 65535);
        run_phase(0, 0);
        run_phase(3, 5);
        run_phase(2, 65535);
        run_phase(65535, 1);
        run_phase($urandom_range(1, 8), $urandom_range(1, 8));

        repeat (8) @(posedge i_clk);
        $display("Covered %0d arrivals (%0d rejected) and %0d ticks under seven quantum settings.",
                 n_accepted + n_rejected, n_rejected, n_ran + n_idle);
        $display("Ticks: %0d ran a task, %0d idle; %0d completions, %0d demotions.",
                 n_ran, n_idle, n_finished, n_demoted);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Sender: bursts of transfers with random gaps in between.
    logic in_fire_q = 1'b0;
    int   send_left = 1;
    int   gap_left = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_fire_q)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (waiting_items.size() > 0) begin
                in_valid <= 1'b1;
                in_item  <= waiting_items[0];
                send_left--;
                if (send_left <= 0) begin
                    send_left = $urandom_range(1, 12);
                    gap_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern steps through four modes as the cycle count advances.
    always @(negedge i_clk) begin
        case ((cycle_count / 150) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (cycle_count % 20) >= 14;
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        in_fire_q <= in_valid && in_ready;
        if (i_rst_n && in_valid && in_ready) void'(waiting_items.pop_front());
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result transfer: expected none, actual %p",
                         $time, out_item);
            end else begin
                want = expected_results.pop_front();
                if (out_item.status != want.status || out_item.run_id != want.run_id ||
                    out_item.run_level != want.run_level ||
                    out_item.finished != want.finished ||
                    out_item.demoted != want.demoted) begin
                    mismatches++;
                    $display("%0t result mismatch: expected %p, actual %p",
                             $time, want, out_item);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
